>>> hdl/evr_pkg.sv
`timescale 1ns / 1ps

package evr_pkg;

    localparam int VEC_W        = 32;
    localparam int ANG_W        = 16;
    localparam int TRIG_W       = 18;
    localparam int ENT_W        = 19;
    localparam int XY_W         = 34;
    localparam int Z_W          = 26;
    localparam int ATAN_W       = 22;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
        logic signed [ANG_W-1:0] pitch_angle;
        logic signed [ANG_W-1:0] roll_angle;
        logic signed [ANG_W-1:0] heading_angle;
        logic                    use_inverse;
    } evr_in_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic signed [VEC_W-1:0] out_z;
    } evr_out_t;

    // one CORDIC channel
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } evr_rot_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sp;
        logic signed [TRIG_W-1:0] cp;
        logic signed [TRIG_W-1:0] sr;
        logic signed [TRIG_W-1:0] cr;
        logic signed [TRIG_W-1:0] sh;
        logic signed [TRIG_W-1:0] ch;
    } evr_trig_t;

    typedef logic signed [ENT_W-1:0] evr_ent_t;
    typedef evr_ent_t [8:0] evr_mat_t;

    // arctangent of 2^-i in 2^-16 degree
    function automatic logic [ATAN_W-1:0] evr_atan(input int i);
        case (i)
            0:       return 22'd2949120;
            1:       return 22'd1740967;
            2:       return 22'd919879;
            3:       return 22'd466945;
            4:       return 22'd234379;
            5:       return 22'd117304;
            6:       return 22'd58666;
            7:       return 22'd29335;
            8:       return 22'd14668;
            9:       return 22'd7334;
            10:      return 22'd3667;
            11:      return 22'd1833;
            12:      return 22'd917;
            13:      return 22'd458;
            14:      return 22'd229;
            15:      return 22'd115;
            16:      return 22'd57;
            17:      return 22'd29;
            18:      return 22'd14;
            19:      return 22'd7;
            20:      return 22'd4;
            21:      return 22'd2;
            22:      return 22'd1;
            default: return 22'd0;
        endcase
    endfunction

    // reduce to +-90 degrees, note the half-turn fold, seed the CORDIC
    function automatic evr_rot_t evr_fold(input logic signed [ANG_W-1:0] a);
        logic signed [16:0] r1;
        logic signed [16:0] r2;
        logic signed [16:0] r3;
        logic signed [Z_W-1:0] zt;
        evr_rot_t o;
        r1 = {a[ANG_W-1], a};
        if (r1 >= 17'sd23040)
            r1 = r1 - 17'sd23040;
        else if (r1 <= -17'sd23040)
            r1 = r1 + 17'sd23040;
        r2 = r1;
        if (r1 >= 17'sd11520)
            r2 = r1 - 17'sd23040;
        else if (r1 < -17'sd11520)
            r2 = r1 + 17'sd23040;
        r3 = r2;
        o.neg = 1'b0;
        if (r2 > 17'sd5760)
        begin
            r3 = r2 - 17'sd11520;
            o.neg = 1'b1;
        end
        else if (r2 < -17'sd5760)
        begin
            r3 = r2 + 17'sd11520;
            o.neg = 1'b1;
        end
        zt = Z_W'(r3);
        o.z = zt <<< 10;
        o.x = CORDIC_X0;
        o.y = '0;
        return o;
    endfunction

    function automatic logic signed [TRIG_W-1:0] evr_trig(
        input logic signed [XY_W-1:0] v,
        input logic                   neg
    );
        logic signed [XY_W-1:0] t;
        t = (v + 34'sd8192) >>> 14;
        if (t > 34'sd65536)
            t = 34'sd65536;
        else if (t < -34'sd65536)
            t = -34'sd65536;
        if (neg)
            t = -t;
        return t[TRIG_W-1:0];
    endfunction

    function automatic logic signed [TRIG_W-1:0] evr_qmul(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic signed [2*TRIG_W-1:0] p;
        p = a * b;
        p = (p + 36'sd32768) >>> 16;
        return p[TRIG_W-1:0];
    endfunction

endpackage

>>> hdl/evr_cordic_cell.sv
`timescale 1ns / 1ps

module evr_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        vld_in,
    input  evr_pkg::evr_rot_t [2:0]     rot_in,
    output logic                        vld_out,
    output evr_pkg::evr_rot_t [2:0]     rot_out
);
    import evr_pkg::*;

    localparam logic [ATAN_W-1:0] ATAN = evr_atan(IDX);
    localparam logic signed [Z_W-1:0] ATAN_S = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN});

    logic                     vld_reg;
    evr_rot_t [2:0]           rot_reg;
    evr_rot_t [2:0]           rot_next;
    logic signed [XY_W-1:0]   dx [3];
    logic signed [XY_W-1:0]   dy [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dx[k] = rot_in[k].y >>> IDX;
            dy[k] = rot_in[k].x >>> IDX;
            rot_next[k].neg = rot_in[k].neg;
            if (!rot_in[k].z[Z_W-1])
            begin
                rot_next[k].x = rot_in[k].x - dx[k];
                rot_next[k].y = rot_in[k].y + dy[k];
                rot_next[k].z = rot_in[k].z - ATAN_S;
            end
            else
            begin
                rot_next[k].x = rot_in[k].x + dx[k];
                rot_next[k].y = rot_in[k].y - dy[k];
                rot_next[k].z = rot_in[k].z + ATAN_S;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rot_reg <= rot_next;
    end

    assign vld_out = vld_reg;
    assign rot_out = rot_reg;

endmodule

>>> hdl/evr_matrix.sv
`timescale 1ns / 1ps

module evr_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_in,
    input  evr_pkg::evr_trig_t   trig,
    output logic                 vld_out,
    output evr_pkg::evr_mat_t    mat
);
    import evr_pkg::*;

    // first products
    logic                      v1_reg;
    logic signed [TRIG_W-1:0]  chsr_reg, shsr_reg, m00_reg, m10_reg, m21_reg, m22_reg;
    logic signed [TRIG_W-1:0]  shcp_reg, shsp_reg, chcp_reg, chsp_reg, sp_reg, cp_reg;
    logic signed [ENT_W-1:0]   m20_reg;
    logic                      v2_reg;
    evr_mat_t                  mat_reg;
    evr_mat_t                  mat_next;

    always_comb
    begin
        mat_next[0] = ENT_W'(m00_reg);
        mat_next[1] = ENT_W'(evr_qmul(chsr_reg, sp_reg)) - ENT_W'(shcp_reg);
        mat_next[2] = ENT_W'(evr_qmul(chsr_reg, cp_reg)) + ENT_W'(shsp_reg);
        mat_next[3] = ENT_W'(m10_reg);
        mat_next[4] = ENT_W'(evr_qmul(shsr_reg, sp_reg)) + ENT_W'(chcp_reg);
        mat_next[5] = ENT_W'(evr_qmul(shsr_reg, cp_reg)) - ENT_W'(chsp_reg);
        mat_next[6] = m20_reg;
        mat_next[7] = ENT_W'(m21_reg);
        mat_next[8] = ENT_W'(m22_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chsr_reg <= evr_qmul(trig.ch, trig.sr);
            shsr_reg <= evr_qmul(trig.sh, trig.sr);
            m00_reg  <= evr_qmul(trig.ch, trig.cr);
            m10_reg  <= evr_qmul(trig.sh, trig.cr);
            m21_reg  <= evr_qmul(trig.cr, trig.sp);
            m22_reg  <= evr_qmul(trig.cr, trig.cp);
            shcp_reg <= evr_qmul(trig.sh, trig.cp);
            shsp_reg <= evr_qmul(trig.sh, trig.sp);
            chcp_reg <= evr_qmul(trig.ch, trig.cp);
            chsp_reg <= evr_qmul(trig.ch, trig.sp);
            sp_reg   <= trig.sp;
            cp_reg   <= trig.cp;
            m20_reg  <= -ENT_W'(trig.sr);
            mat_reg  <= mat_next;
        end
    end

    assign vld_out = v2_reg;
    assign mat     = mat_reg;

endmodule

>>> hdl/evr_lane.sv
`timescale 1ns / 1ps

module evr_lane (
    input  logic                                   clk,
    input  logic                                   en,
    input  evr_pkg::evr_ent_t [2:0]                row,
    input  logic [2:0][evr_pkg::VEC_W-1:0]         vec,
    output logic signed [evr_pkg::VEC_W-1:0]       res
);
    import evr_pkg::*;

    localparam int PW = ENT_W + VEC_W;
    localparam int SW = PW + 2;

    localparam logic signed [SW-1:0] MAXV = $signed({{(SW-VEC_W+1){1'b0}}, {(VEC_W-1){1'b1}}});
    localparam logic signed [SW-1:0] MINV = $signed({{(SW-VEC_W+1){1'b1}}, {(VEC_W-1){1'b0}}});

    logic signed [PW-1:0] prod_next [3];
    logic signed [PW-1:0] prod_reg  [3];
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] shf;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod_next[k] = $signed(row[k]) * $signed(vec[k]);
        sum_next = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2])
                 + SW'(32'sd32768);
        shf = sum_reg >>> 16;
        if (shf > MAXV)
            res = MAXV[VEC_W-1:0];
        else if (shf < MINV)
            res = MINV[VEC_W-1:0];
        else
            res = shf[VEC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

>>> hdl/euler_vector_rotate.sv
`timescale 1ns / 1ps

// One CORDIC cell per step, three angles side by side.
// Throughput: one beat per cycle while no held result is stalled.
// The whole pipeline advances unless a held result is stalled.
// Reset clears all valid flags; payload registers are not reset.
module euler_vector_rotate #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  evr_pkg::evr_in_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output evr_pkg::evr_out_t  result
);
    import evr_pkg::*;

    localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int DLY  = NSTG + 4;

    typedef struct packed {
        logic [2:0][VEC_W-1:0] vec;
        logic                  inv;
    } evr_vec_t;

    logic            en;
    logic            s0_vld_reg;
    evr_rot_t [2:0]  s0_rot_reg;
    logic            chain_vld [NSTG+1];
    evr_rot_t [2:0]  chain_rot [NSTG+1];
    logic            trig_vld_reg;
    evr_trig_t       trig_reg;
    logic            mat_vld;
    evr_mat_t        mat;
    evr_vec_t        dly_reg [DLY];
    logic            vp_reg;
    logic            vs_reg;
    logic            result_valid_reg;
    evr_out_t        result_reg;
    evr_out_t        result_next;
    evr_ent_t [2:0]  rows [3];
    logic signed [VEC_W-1:0] res [3];

    assign en         = !(result_valid_reg && result_stall);
    assign item_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg       <= 1'b0;
            trig_vld_reg     <= 1'b0;
            vp_reg           <= 1'b0;
            vs_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg       <= item_valid;
            trig_vld_reg     <= chain_vld[NSTG];
            vp_reg           <= mat_vld;
            vs_reg           <= vp_reg;
            result_valid_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_rot_reg[0] <= evr_fold(item.pitch_angle);
            s0_rot_reg[1] <= evr_fold(item.roll_angle);
            s0_rot_reg[2] <= evr_fold(item.heading_angle);
            trig_reg.sp   <= evr_trig(chain_rot[NSTG][0].y, chain_rot[NSTG][0].neg);
            trig_reg.cp   <= evr_trig(chain_rot[NSTG][0].x, chain_rot[NSTG][0].neg);
            trig_reg.sr   <= evr_trig(chain_rot[NSTG][1].y, chain_rot[NSTG][1].neg);
            trig_reg.cr   <= evr_trig(chain_rot[NSTG][1].x, chain_rot[NSTG][1].neg);
            trig_reg.sh   <= evr_trig(chain_rot[NSTG][2].y, chain_rot[NSTG][2].neg);
            trig_reg.ch   <= evr_trig(chain_rot[NSTG][2].x, chain_rot[NSTG][2].neg);
            dly_reg[0].vec <= {item.vec_z, item.vec_y, item.vec_x};
            dly_reg[0].inv <= item.use_inverse;
            for (int k = 1; k < DLY; k++)
                dly_reg[k] <= dly_reg[k-1];
            result_reg <= result_next;
        end
    end

    assign chain_vld[0] = s0_vld_reg;
    assign chain_rot[0] = s0_rot_reg;

    for (genvar g = 0; g < NSTG; g++)
    begin : g_cell
        evr_cordic_cell #(.IDX(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (chain_vld[g]),
            .rot_in  (chain_rot[g]),
            .vld_out (chain_vld[g+1]),
            .rot_out (chain_rot[g+1])
        );
    end

    evr_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (trig_vld_reg),
        .trig    (trig_reg),
        .vld_out (mat_vld),
        .mat     (mat)
    );

    // transpose selects column instead of row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rows[i][j] = dly_reg[DLY-1].inv ? mat[3*j+i] : mat[3*i+j];
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        evr_lane u_lane (
            .clk (clk),
            .en  (en),
            .row (rows[g]),
            .vec (dly_reg[DLY-1].vec),
            .res (res[g])
        );
    end

    always_comb
    begin
        result_next.out_x = res[0];
        result_next.out_y = res[1];
        result_next.out_z = res[2];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
